FILE: hdl/tnmh_pkg.sv
// Shared types and constants for the top-N min-heap tracker.
// No dependencies; every other file refers to it by scoped names.
package tnmh_pkg;

    localparam int HEAP_DEPTH = 64;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int KEY_W      = 32;
    localparam int TAG_W      = 32;
    localparam int CAP_W      = 7;
    localparam int CNT_OUT_W  = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef struct packed {
        logic [KEY_W-1:0] item_key;
        logic [TAG_W-1:0] item_tag;
    } t_item;

    typedef struct packed {
        logic                 accepted;
        logic                 evicted_valid;
        logic [KEY_W-1:0]     evicted_key;
        logic [TAG_W-1:0]     evicted_tag;
        logic [CNT_OUT_W-1:0] entry_count_out;
        logic [KEY_W-1:0]     minimum_key;
    } t_result;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_children;
        logic wr_new;
        logic inc_count;
        logic mv_up;
        logic mv_dn;
    } t_dp_cmd;

    typedef struct packed {
        logic do_append;
        logic do_replace;
        logic at_root;
        logic up_stop;
        logic no_child;
        logic dn_stop;
    } t_dp_status;

endpackage

FILE: hdl/tnmh_ctrl.sv
// Sequencer for the top-N min-heap: load, sift up or sift down, report.
// Depends on tnmh_pkg.
module tnmh_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  tnmh_pkg::t_dp_status i_status,
    output tnmh_pkg::t_dp_cmd    o_cmd,
    output logic                 o_busy,
    output logic                 o_strobe
);

    tnmh_pkg::t_state r_state;
    tnmh_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tnmh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tnmh_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_status.do_append) begin
                        n_state = tnmh_pkg::ST_UP_RD;
                    end else if (i_status.do_replace) begin
                        n_state = tnmh_pkg::ST_DN_RD;
                    end else begin
                        n_state = tnmh_pkg::ST_DONE;
                    end
                end
            end
            tnmh_pkg::ST_UP_RD: begin
                n_state = i_status.at_root ? tnmh_pkg::ST_DONE : tnmh_pkg::ST_UP_CMP;
            end
            tnmh_pkg::ST_UP_CMP: begin
                n_state = i_status.up_stop ? tnmh_pkg::ST_DONE : tnmh_pkg::ST_UP_RD;
            end
            tnmh_pkg::ST_DN_RD: begin
                n_state = i_status.no_child ? tnmh_pkg::ST_DONE : tnmh_pkg::ST_DN_CMP;
            end
            tnmh_pkg::ST_DN_CMP: begin
                n_state = i_status.dn_stop ? tnmh_pkg::ST_DONE : tnmh_pkg::ST_DN_RD;
            end
            tnmh_pkg::ST_DONE: begin
                n_state = tnmh_pkg::ST_IDLE;
            end
            default: begin
                n_state = tnmh_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        o_busy   = 1'b1;
        o_strobe = 1'b0;
        unique case (r_state)
            tnmh_pkg::ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            tnmh_pkg::ST_UP_RD: begin
                o_cmd.wr_new    = i_status.at_root;
                o_cmd.inc_count = i_status.at_root;
            end
            tnmh_pkg::ST_UP_CMP: begin
                o_cmd.wr_new    = i_status.up_stop;
                o_cmd.inc_count = i_status.up_stop;
                o_cmd.mv_up     = !i_status.up_stop;
            end
            tnmh_pkg::ST_DN_RD: begin
                o_cmd.rd_children = 1'b1;
                o_cmd.wr_new      = i_status.no_child;
            end
            tnmh_pkg::ST_DN_CMP: begin
                o_cmd.wr_new = i_status.dn_stop;
                o_cmd.mv_dn  = !i_status.dn_stop;
            end
            tnmh_pkg::ST_DONE: begin
                o_strobe = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

FILE: hdl/tnmh_dp.sv
// Datapath for the top-N min-heap: entry memory, hole position, count,
// root copy, capacity register and result registers. Depends on tnmh_pkg.
module tnmh_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tnmh_pkg::t_item                    i_item,
    input  logic                               i_cfg_we,
    input  logic [tnmh_pkg::CAP_W-1:0]         i_cfg_wdata,
    input  tnmh_pkg::t_dp_cmd                  i_cmd,
    output tnmh_pkg::t_dp_status               o_status,
    output tnmh_pkg::t_result                  o_result
);

    tnmh_pkg::t_entry r_mem [tnmh_pkg::HEAP_DEPTH];

    logic [tnmh_pkg::CAP_W-1:0]  r_cap;
    logic [tnmh_pkg::CNT_W-1:0]  r_count;
    logic [tnmh_pkg::ADDR_W-1:0] r_pos;
    tnmh_pkg::t_entry            r_new;
    tnmh_pkg::t_entry            r_root;
    tnmh_pkg::t_entry            r_rd_a;
    tnmh_pkg::t_entry            r_rd_b;
    logic                        r_accepted;
    logic                        r_ev_valid;
    tnmh_pkg::t_entry            r_ev;

    logic [tnmh_pkg::CNT_W-1:0]  cap_eff;
    logic                        do_append;
    logic                        do_replace;
    logic [tnmh_pkg::ADDR_W-1:0] parent;
    logic [tnmh_pkg::ADDR_W:0]   left;
    logic [tnmh_pkg::ADDR_W:0]   right;
    logic                        right_ok;
    logic                        pick_right;
    logic [tnmh_pkg::ADDR_W-1:0] pick_addr;
    tnmh_pkg::t_entry            pick;
    logic [tnmh_pkg::ADDR_W-1:0] rd_addr_a;
    logic                        wr_en;
    tnmh_pkg::t_entry            wr_data;

    // capacity above the heap depth acts as the depth
    assign cap_eff = (32'(r_cap) > 32'(tnmh_pkg::HEAP_DEPTH)) ?
                     tnmh_pkg::CNT_W'(tnmh_pkg::HEAP_DEPTH) : tnmh_pkg::CNT_W'(r_cap);

    assign do_append  = 32'(r_count) < 32'(cap_eff);
    assign do_replace = !do_append && (r_count != '0) && (i_item.item_key > r_root.key);

    assign parent   = (r_pos - tnmh_pkg::ADDR_W'(1)) >> 1;
    assign left     = {r_pos, 1'b1};
    assign right    = left + (tnmh_pkg::ADDR_W+1)'(1);
    assign right_ok = 32'(right) < 32'(r_count);

    assign pick_right = right_ok && (r_rd_b.key < r_rd_a.key);
    assign pick       = pick_right ? r_rd_b : r_rd_a;
    assign pick_addr  = pick_right ? right[tnmh_pkg::ADDR_W-1:0] : left[tnmh_pkg::ADDR_W-1:0];

    assign rd_addr_a = i_cmd.rd_children ? left[tnmh_pkg::ADDR_W-1:0] : parent;

    assign o_status.do_append  = do_append;
    assign o_status.do_replace = do_replace;
    assign o_status.at_root    = (r_pos == '0);
    assign o_status.up_stop    = r_new.key >= r_rd_a.key;
    assign o_status.no_child   = 32'(left) >= 32'(r_count);
    // parallel compares against both children, then select
    assign o_status.dn_stop    = pick_right ? (r_new.key <= r_rd_b.key)
                                            : (r_new.key <= r_rd_a.key);

    assign wr_en = i_cmd.wr_new | i_cmd.mv_up | i_cmd.mv_dn;

    always_comb begin
        priority if (i_cmd.wr_new) begin
            wr_data = r_new;
        end else if (i_cmd.mv_up) begin
            wr_data = r_rd_a;
        end else begin
            wr_data = pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[right[tnmh_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && (r_pos == '0)) begin
            r_root <= wr_data;
        end
        if (i_cmd.load) begin
            r_new.key  <= i_item.item_key;
            r_new.tag  <= i_item.item_tag;
            r_accepted <= do_append | do_replace;
            r_ev_valid <= do_replace;
            r_ev       <= do_replace ? r_root : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= tnmh_pkg::CAP_RESET;
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.inc_count) begin
                r_count <= r_count + tnmh_pkg::CNT_W'(1);
            end
            priority if (i_cmd.load) begin
                r_pos <= do_append ? tnmh_pkg::ADDR_W'(r_count) : '0;
            end else if (i_cmd.mv_up) begin
                r_pos <= parent;
            end else if (i_cmd.mv_dn) begin
                r_pos <= pick_addr;
            end
        end
    end

    assign o_result.accepted        = r_accepted;
    assign o_result.evicted_valid   = r_ev_valid;
    assign o_result.evicted_key     = r_ev.key;
    assign o_result.evicted_tag     = r_ev.tag;
    assign o_result.entry_count_out = tnmh_pkg::CNT_OUT_W'(r_count);
    assign o_result.minimum_key     = (r_count != '0) ? r_root.key : '0;

endmodule

FILE: hdl/top_n_min_heap_top.sv
// Top level of the top-N min-heap tracker: sequencer plus datapath.
// Depends on tnmh_pkg, tnmh_ctrl and tnmh_dp.
//
// Channel  | Signals                           | Transfer when
// ---------+-----------------------------------+------------------------------
// item in  | start, busy, i_item               | start && !busy
// result   | o_result_strobe, o_result         | o_result_strobe (no stall)
// config   | i_cfg_we, i_cfg_wdata             | i_cfg_we
//
// A rejected item goes from idle straight to the result state. Otherwise the
// sift ends at the root, at a leaf or when a compare stops it: each heap level
// moved costs a memory read state and a compare/write state. busy is high from
// the transfer through the result strobe. Reset clears the count and sets
// capacity to 64; heap memory is not cleared. Results cannot be held off by
// the receiver.
module top_n_min_heap_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  tnmh_pkg::t_item            i_item,
    output logic                       o_result_strobe,
    output tnmh_pkg::t_result          o_result,
    input  logic                       i_cfg_we,
    input  logic [tnmh_pkg::CAP_W-1:0] i_cfg_wdata
);

    tnmh_pkg::t_dp_cmd    cmd;
    tnmh_pkg::t_dp_status status;

    tnmh_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_result_strobe)
    );

    tnmh_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (o_result)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not raise busy");

    a_strobe_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !busy)
        else $error("busy held after result");

    a_evict_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.evicted_valid) |-> o_result.accepted)
        else $error("eviction without accept");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |->
            (32'(o_result.entry_count_out) <= 32'(tnmh_pkg::HEAP_DEPTH)))
        else $error("count beyond heap depth");

endmodule

FILE: verif/tnmh_checker.sv
// Checker for the top-N min-heap tracker: watches item, config and result channels.
// Keeps its own heap copy to predict each result and compares field by field.
// Depends on tnmh_pkg.
module tnmh_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  tnmh_pkg::t_item            i_item,
    input  logic                       i_result_strobe,
    input  tnmh_pkg::t_result          i_result,
    input  logic                       i_cfg_we,
    input  logic [tnmh_pkg::CAP_W-1:0] i_cfg_wdata,
    output int                         o_errors,
    output int                         o_pending
);

    tnmh_pkg::t_entry           heap_mem [tnmh_pkg::HEAP_DEPTH];
    int unsigned                held;
    logic [tnmh_pkg::CAP_W-1:0] cap_reg;
    tnmh_pkg::t_result          results_due [$];
    int                         errors;
    int                         pending;

    assign o_errors  = errors;
    assign o_pending = pending;

    initial begin
        errors  = 0;
        pending = 0;
        held    = 0;
        cap_reg = tnmh_pkg::CAP_RESET;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR: %s got %h expected %h", what, got, want);
        errors++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    function automatic void swap_entries(input int unsigned a, input int unsigned b);
        tnmh_pkg::t_entry t;
        t           = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endfunction

    // Insert, replace the root or reject, and return the result of the step.
    function automatic tnmh_pkg::t_result insert_top_n(input tnmh_pkg::t_item it);
        tnmh_pkg::t_result r;
        int unsigned       cap;
        int unsigned       pos;
        int unsigned       up;
        int unsigned       pick;
        r   = '0;
        cap = (cap_reg > tnmh_pkg::HEAP_DEPTH) ? tnmh_pkg::HEAP_DEPTH : cap_reg;
        if (held < cap) begin
            heap_mem[held] = '{key: it.item_key, tag: it.item_tag};
            pos = held;
            while (pos > 0) begin
                up = (pos - 1) / 2;
                if (heap_mem[pos].key >= heap_mem[up].key) break;
                swap_entries(pos, up);
                pos = up;
            end
            held++;
            r.accepted = 1'b1;
        end else if (held > 0 && it.item_key > heap_mem[0].key) begin
            r.accepted      = 1'b1;
            r.evicted_valid = 1'b1;
            r.evicted_key   = heap_mem[0].key;
            r.evicted_tag   = heap_mem[0].tag;
            heap_mem[0]     = '{key: it.item_key, tag: it.item_tag};
            pos = 0;
            while (2 * pos + 1 < held) begin
                pick = 2 * pos + 1;
                if (pick + 1 < held && heap_mem[pick + 1].key < heap_mem[pick].key) begin
                    pick = pick + 1;
                end
                if (heap_mem[pos].key <= heap_mem[pick].key) break;
                swap_entries(pos, pick);
                pos = pick;
            end
        end
        r.entry_count_out = tnmh_pkg::CNT_OUT_W'(held);
        r.minimum_key     = (held > 0) ? heap_mem[0].key : '0;
        return r;
    endfunction

    // Sampled mid-cycle: inputs and outputs are stable, and a transfer seen
    // here happens at the coming rising edge.
    always @(negedge i_clk) begin
        tnmh_pkg::t_result want;
        if (!i_rst_n) begin
            held    = 0;
            cap_reg = tnmh_pkg::CAP_RESET;
            results_due.delete();
        end else begin
            if (i_result_strobe) begin
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected result", 32'(i_result.minimum_key), '0);
                end else begin
                    want = results_due.pop_front();
                    check_field("accepted", 32'(i_result.accepted), 32'(want.accepted));
                    check_field("evicted_valid", 32'(i_result.evicted_valid),
                                32'(want.evicted_valid));
                    check_field("evicted_key", i_result.evicted_key, want.evicted_key);
                    check_field("evicted_tag", i_result.evicted_tag, want.evicted_tag);
                    check_field("entry_count_out", 32'(i_result.entry_count_out),
                                32'(want.entry_count_out));
                    check_field("minimum_key", i_result.minimum_key, want.minimum_key);
                end
            end
            if (i_cfg_we) begin
                cap_reg = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                results_due.push_back(insert_top_n(i_item));
            end
        end
        pending = results_due.size();
    end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the top-N min-heap tracker: clock, reset, stimulus, verdict.
// Depends on tnmh_pkg, top_n_min_heap_top and tnmh_checker.
module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 14;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    tnmh_pkg::t_item            i_item = '0;
    logic                       o_result_strobe;
    tnmh_pkg::t_result          o_result;
    logic                       i_cfg_we = 1'b0;
    logic [tnmh_pkg::CAP_W-1:0] i_cfg_wdata = '0;
    int                         errors;
    int                         pending;
    int                         cycles = 0;
    int                         idle_pct = 0;
    logic [tnmh_pkg::KEY_W-1:0] last_min = '0;

    top_n_min_heap_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    tnmh_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_item          (i_item),
        .i_result_strobe (o_result_strobe),
        .i_result        (o_result),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (o_result_strobe) begin
            last_min <= o_result.minimum_key;
        end
    end

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [tnmh_pkg::CAP_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Returns at the rising edge of the transfer; start stays high.
    task automatic send_item(input logic [tnmh_pkg::KEY_W-1:0] key,
                             input logic [tnmh_pkg::TAG_W-1:0] tag);
        bit taken;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= '{item_key: key, item_tag: tag};
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
    endtask

    function automatic logic [tnmh_pkg::KEY_W-1:0] pick_key();
        logic [tnmh_pkg::KEY_W:0] near;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return tnmh_pkg::KEY_W'($urandom_range(0, 15));
            2: begin
                near = {1'b0, last_min} + $urandom_range(0, 255);
                return near[tnmh_pkg::KEY_W] ? '1 : near[tnmh_pkg::KEY_W-1:0];
            end
            default: return '1 - tnmh_pkg::KEY_W'($urandom_range(0, 15));
        endcase
    endfunction

    initial begin
        logic [tnmh_pkg::CAP_W-1:0] phase_cap [PHASES];
        int n_items;

        phase_cap = '{7'd12, 7'd25, 7'd0, 7'd40, 7'd1, 7'd127, 7'd3, 7'd64,
                      7'd100, 7'd63, 7'd2, 7'd64, 7'd0, 7'd64};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty heap with zero capacity rejects everything
        write_capacity(7'd0);
        send_item('1, '1);
        send_item('0, '0);
        // single slot: append, equal-to-root reject, smaller-than-root reject, replace
        start <= 1'b0;
        write_capacity(7'd1);
        send_item(32'd5, 32'hA5A5_5A5A);
        send_item(32'd5, 32'h1111_1111);
        send_item('0, 32'h2222_2222);
        send_item('1, '1);
        // capacity above depth acts as depth
        start <= 1'b0;
        write_capacity(7'd127);
        send_item('0, 32'd1);
        send_item('0, 32'd2);
        send_item(32'd7, 32'd3);
        send_item('1, 32'd4);
        send_item(32'd1, 32'd5);
        // capacity below count: replace only
        start <= 1'b0;
        write_capacity(7'd2);
        send_item('0, 32'd6);
        send_item(32'd3, 32'd7);
        send_item(32'd3, 32'd8);
        send_item(32'h8000_0000, 32'h7FFF_FFFF);
        start <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            write_capacity(phase_cap[p]);
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 66;
                default: idle_pct = 10;
            endcase
            n_items = $urandom_range(60, 75);
            for (int k = 0; k < n_items; k++) begin
                send_item(pick_key(), $urandom);
            end
            start <= 1'b0;
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
